FILE: rtl/core/running_median_window_core_assert.svh
// assertion macros shared by the running median window rtl
`ifndef RUNNING_MEDIAN_WINDOW_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_WINDOW_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define RMW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running median window: same-cycle check failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define RMW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("running median window: next-cycle check failed");

`endif

FILE: rtl/core/rmw_pkg.sv
// shared types and constants of the running median window
package rmw_pkg;

  // window size register
  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd3;

  // defaults for the top level parameters
  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // control of the window store for one cycle
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } rmw_mem_ctl_t;

endpackage

FILE: rtl/core/rmw_store.sv
// window store: one write and one registered read per cycle, valid bit per entry
module rmw_store
  import rmw_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WINDOW,
  parameter int DATA_W = DEF_SAMPLE_BITS,
  parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rmw_mem_ctl_t             ctl,
  input  logic [IDX_W-1:0]         waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]         raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         valid;
  logic signed [DATA_W-1:0] rdata_q;
  logic                     rvalid_q;

  // memory array write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // per-entry valid bits, an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[waddr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvalid_q <= valid[raddr];
      end
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

FILE: rtl/core/rmw_swap_unit.sv
// shared compare and select unit for one bubble step
module rmw_swap_unit
  import rmw_pkg::*;
#(
  parameter int DATA_W = DEF_SAMPLE_BITS
) (
  input  logic signed [DATA_W-1:0] carry,
  input  logic signed [DATA_W-1:0] nb,
  input  logic                     up,
  output logic                     move,
  output logic signed [DATA_W-1:0] wr_val,
  output logic signed [DATA_W-1:0] carry_next
);

  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;

  // one strict comparator, operands swapped for the downward pass
  assign op_a = up ? carry : nb;
  assign op_b = up ? nb : carry;
  assign move = op_a > op_b;

  // the neighbour drops into the slot when the carried value keeps moving
  assign wr_val     = move ? nb : carry;
  assign carry_next = move ? carry : nb;

endmodule

FILE: rtl/core/running_median_window_core.sv
// running median window: sequencer, window size register and output stage
//
// Each sample is written into a nearly sorted window at the write position,
// then one bubble pass (up or down, chosen by the slot's neighbours) walks
// from that slot to the end of the window, one compare and one store write
// per cycle, and the entry at index size/2 is returned as the median. An
// item passes through the probe state, a decide state in a larger window,
// the step and last states as a pass needs them, and the median read and
// result states; a new sample is taken only once the previous median is in
// the output register, and a pass uses the single compare unit and the
// one-write one-read window store. A write of window_size clears the store
// and the write position at once (per-entry valid bits), with no clearing
// pass, and takes precedence over a sample offered in the same cycle; a
// size of 0 acts as 1 and a size above MAX_WINDOW acts as MAX_WINDOW.
`include "running_median_window_core_assert.svh"

module running_median_window_core
  import rmw_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  // input samples
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  // medians
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [SAMPLE_BITS-1:0] median
  // window size register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PROBE  = 3'd1;
  localparam logic [2:0] S_DEC_UP = 3'd2;
  localparam logic [2:0] S_DEC_DN = 3'd3;
  localparam logic [2:0] S_STEP   = 3'd4;
  localparam logic [2:0] S_LAST   = 3'd5;
  localparam logic [2:0] S_MED    = 3'd6;
  localparam logic [2:0] S_RES    = 3'd7;

  logic [2:0]                    state, state_next;
  logic [CFG_W-1:0]              window_size;
  logic [IDX_W-1:0]              wpos;
  logic [CNT_W-1:0]              n_q;
  logic [IDX_W-1:0]              pos, pos_next;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] carry, carry_next;
  logic                          dir_up, dir_up_next;
  logic signed [SAMPLE_BITS-1:0] median_q;
  logic                          out_valid;

  logic                          in_acc;
  logic                          cfg_acc;
  logic                          out_free;
  logic [CMP_W-1:0]              ws_ext;
  logic [CMP_W-1:0]              eff_ext;
  logic [CNT_W-1:0]              n_eff;
  logic [IDX_W-1:0]              p_start;
  logic [CNT_W-1:0]              p_inc;
  logic [CNT_W:0]                pos_p1, pos_p2, n_w;
  logic                          has_up, has_up2;

  rmw_mem_ctl_t                  mem_ctl;
  logic [IDX_W-1:0]              waddr, raddr;
  logic signed [SAMPLE_BITS-1:0] wdata, rdata;

  logic                          unit_up, unit_move;
  logic signed [SAMPLE_BITS-1:0] unit_wr, unit_carry;
  logic                          do_step, step_up;

  // handshakes, a size write wins over a sample in the same cycle
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid && cfg_ready;
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == S_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  // effective window size and start slot
  assign ws_ext  = CMP_W'(window_size);
  assign eff_ext = (window_size == '0) ? CMP_W'(1) :
                   ((ws_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : ws_ext);
  assign n_eff   = eff_ext[CNT_W-1:0];
  assign p_start = (CNT_W'(wpos) >= n_eff) ? '0 : wpos;
  assign p_inc   = CNT_W'(p_start) + CNT_W'(1);

  // neighbour bounds for the current slot
  assign pos_p1  = (CNT_W+1)'(pos) + (CNT_W+1)'(1);
  assign pos_p2  = (CNT_W+1)'(pos) + (CNT_W+1)'(2);
  assign n_w     = (CNT_W+1)'(n_q);
  assign has_up  = pos_p1 < n_w;
  assign has_up2 = pos_p2 < n_w;

  // shared compare unit
  assign unit_up = (state == S_STEP) ? dir_up : (state != S_DEC_DN);
  assign do_step = (state == S_STEP) ||
                   (((state == S_DEC_UP) || (state == S_DEC_DN)) && unit_move);
  assign step_up = unit_up;

  rmw_swap_unit #(
    .DATA_W(SAMPLE_BITS)
  ) u_swap (
    .carry     (carry),
    .nb        (rdata),
    .up        (unit_up),
    .move      (unit_move),
    .wr_val    (unit_wr),
    .carry_next(unit_carry)
  );

  // sequencer
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    carry_next    = carry;
    dir_up_next   = dir_up;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    mem_ctl.clear = cfg_acc;
    waddr         = pos;
    wdata         = carry;
    raddr         = IDX_W'(pos_p1);
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_PROBE;
          pos_next   = p_start;
          carry_next = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
        end
      end
      S_PROBE: begin
        mem_ctl.wr_en = 1'b1;
        wdata         = sample_q;
        if (has_up) begin
          mem_ctl.rd_en = 1'b1;
          raddr         = IDX_W'(pos_p1);
          state_next    = S_DEC_UP;
        end else if (pos != '0) begin
          mem_ctl.rd_en = 1'b1;
          raddr         = pos - IDX_W'(1);
          state_next    = S_DEC_DN;
        end else begin
          state_next = S_MED;
        end
      end
      S_DEC_UP, S_DEC_DN, S_STEP: begin
        if (do_step) begin
          mem_ctl.wr_en = 1'b1;
          wdata         = unit_wr;
          carry_next    = unit_carry;
          dir_up_next   = step_up;
          if (step_up) begin
            pos_next = pos + IDX_W'(1);
            if (has_up2) begin
              mem_ctl.rd_en = 1'b1;
              raddr         = IDX_W'(pos_p2);
              state_next    = S_STEP;
            end else begin
              state_next = S_LAST;
            end
          end else begin
            pos_next = pos - IDX_W'(1);
            if (pos > IDX_W'(1)) begin
              mem_ctl.rd_en = 1'b1;
              raddr         = pos - IDX_W'(2);
              state_next    = S_STEP;
            end else begin
              state_next = S_LAST;
            end
          end
        end else if ((state == S_DEC_UP) && (pos != '0)) begin
          mem_ctl.rd_en = 1'b1;
          raddr         = pos - IDX_W'(1);
          state_next    = S_DEC_DN;
        end else begin
          state_next = S_MED;
        end
      end
      S_LAST: begin
        mem_ctl.wr_en = 1'b1;
        wdata         = carry;
        state_next    = S_MED;
      end
      S_MED: begin
        mem_ctl.rd_en = 1'b1;
        raddr         = IDX_W'(n_q >> 1);
        state_next    = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  rmw_store #(
    .DEPTH (MAX_WINDOW),
    .DATA_W(SAMPLE_BITS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mem_ctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= CFG_RESET;
      wpos        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        window_size <= cfg_data;
        wpos        <= '0;
      end else if (in_acc) begin
        wpos <= (p_inc == n_eff) ? '0 : IDX_W'(p_inc);
      end
      if ((state == S_RES) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pass datapath registers
  always_ff @(posedge clk) begin
    pos    <= pos_next;
    carry  <= carry_next;
    dir_up <= dir_up_next;
    if (in_acc) begin
      sample_q <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      n_q      <= n_eff;
    end
    if ((state == S_RES) && out_free) begin
      median_q <= rdata;
    end
  end

  // output beat
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'($unsigned(median_q));

  `RMW_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `RMW_ASSERT_IMP(a_step_in_window, state == S_STEP, CNT_W'(pos) < n_q)
  `RMW_ASSERT_IMP(a_wpos_in_window, state != S_IDLE, CNT_W'(wpos) < n_q)
  `RMW_ASSERT_NEXT(a_result_loaded, (state == S_RES) && out_free, m_axis_tvalid && (state == S_IDLE))

endmodule
